// File: src/msbbp_pkg.sv
// Shared types and constants for the MSB-first bit packer.
// No dependencies; used by msbbp_ctrl, msbbp_datapath and msb_first_bit_packer.
package msbbp_pkg;

    // Width of the wrapping stream byte counter (8..32).
    localparam int INDEX_BITS = 16;
    localparam int FIELD_BITS = 32;
    localparam int NBITS_W    = 6;
    localparam int BYTE_BITS  = 8;
    localparam int IDX_OUT_W  = 16;
    // Pending bits: up to 7 leftover plus one full field.
    localparam int ACC_W      = FIELD_BITS + BYTE_BITS;
    localparam int TOTAL_W    = $clog2(ACC_W + 1);
    localparam int IN_DATA_W  = ((FIELD_BITS + NBITS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((BYTE_BITS + IDX_OUT_W + 7) / 8) * 8;

    // tuser code on the input side
    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load;   // append the accepted field
        logic pop;    // emit one completed byte
        logic flush;  // emit padded partial byte and restart stream
    } dp_cmd_t;

    typedef struct packed {
        logic slot_free;    // output register can take a byte this cycle
        logic has_byte;     // at least 8 pending bits
        logic last_byte;    // the next popped byte is the final one
        logic load_yields;  // the field being loaded completes a byte
    } dp_status_t;

endpackage

// File: src/msbbp_ctrl.sv
// Controller state machine of the MSB-first bit packer.
// Depends on msbbp_pkg; drives msbbp_datapath through dp_cmd_t.
module msbbp_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_action,
    output logic                  in_ready,
    input  msbbp_pkg::dp_status_t status,
    output msbbp_pkg::dp_cmd_t    cmd
);

    msbbp_pkg::state_t state_reg;
    msbbp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msbbp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msbbp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_action == msbbp_pkg::ACT_FLUSH)
                    begin
                        state_next = msbbp_pkg::ST_FLUSH;
                    end
                    else if (status.load_yields)
                    begin
                        state_next = msbbp_pkg::ST_EMIT;
                    end
                end
            end
            msbbp_pkg::ST_EMIT:
            begin
                if (status.slot_free && (status.last_byte || !status.has_byte))
                begin
                    state_next = msbbp_pkg::ST_IDLE;
                end
            end
            msbbp_pkg::ST_FLUSH:
            begin
                if (status.slot_free)
                begin
                    state_next = msbbp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msbbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        cmd       = '0;
        case (state_reg)
            msbbp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid && (in_action == msbbp_pkg::ACT_PUSH);
            end
            msbbp_pkg::ST_EMIT:
            begin
                cmd.pop = status.slot_free && status.has_byte;
            end
            msbbp_pkg::ST_FLUSH:
            begin
                cmd.flush = status.slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: src/msbbp_datapath.sv
// Datapath of the MSB-first bit packer: bit accumulator, byte counter, output register.
// Depends on msbbp_pkg; commanded by msbbp_ctrl.
module msbbp_datapath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [msbbp_pkg::FIELD_BITS-1:0]       field_value,
    input  logic [msbbp_pkg::NBITS_W-1:0]          num_bits,
    input  msbbp_pkg::dp_cmd_t                     cmd,
    output msbbp_pkg::dp_status_t                  status,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [msbbp_pkg::BYTE_BITS-1:0]        out_byte,
    output logic [msbbp_pkg::IDX_OUT_W-1:0]        byte_index,
    output logic                                   out_last
);

    // Pending bits sit right aligned in acc; bits above total are don't-care.
    logic [msbbp_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic [msbbp_pkg::TOTAL_W-1:0]    total_reg, total_next;
    logic [msbbp_pkg::INDEX_BITS-1:0] cnt_reg, cnt_next;
    logic                             ovalid_reg, ovalid_next;
    logic [msbbp_pkg::BYTE_BITS-1:0]  obyte_reg, obyte_next;
    logic [msbbp_pkg::IDX_OUT_W-1:0]  oidx_reg, oidx_next;
    logic                             olast_reg, olast_next;

    logic [msbbp_pkg::NBITS_W-1:0]    n_clamped;
    logic [63:0]                      mask_wide;
    logic [msbbp_pkg::FIELD_BITS-1:0] value_masked;
    logic [msbbp_pkg::TOTAL_W-1:0]    total_loaded;
    logic [msbbp_pkg::ACC_W-1:0]      acc_shifted;
    logic [msbbp_pkg::ACC_W-1:0]      acc_flush;
    logic [31:0]                      cnt_wide;
    logic                             slot_free;

    assign n_clamped    = (num_bits > msbbp_pkg::NBITS_W'(msbbp_pkg::FIELD_BITS))
                        ? msbbp_pkg::NBITS_W'(msbbp_pkg::FIELD_BITS) : num_bits;
    assign mask_wide    = ~(64'hFFFF_FFFF_FFFF_FFFF << n_clamped);
    assign value_masked = field_value & mask_wide[msbbp_pkg::FIELD_BITS-1:0];
    assign total_loaded = total_reg + msbbp_pkg::TOTAL_W'(n_clamped);

    // oldest unread byte and the padded partial byte
    assign acc_shifted  = acc_reg >> (total_reg - msbbp_pkg::TOTAL_W'(msbbp_pkg::BYTE_BITS));
    assign acc_flush    = acc_reg << (msbbp_pkg::TOTAL_W'(msbbp_pkg::BYTE_BITS) - total_reg);
    assign cnt_wide     = 32'(cnt_reg);
    assign slot_free    = !ovalid_reg || out_ready;

    assign status.slot_free   = slot_free;
    assign status.has_byte    = total_reg >= msbbp_pkg::TOTAL_W'(msbbp_pkg::BYTE_BITS);
    assign status.last_byte   = total_reg < msbbp_pkg::TOTAL_W'(2 * msbbp_pkg::BYTE_BITS);
    assign status.load_yields = (n_clamped != '0)
                             && (total_loaded >= msbbp_pkg::TOTAL_W'(msbbp_pkg::BYTE_BITS));

    always_comb
    begin
        acc_next    = acc_reg;
        total_next  = total_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg && !out_ready;
        obyte_next  = obyte_reg;
        oidx_next   = oidx_reg;
        olast_next  = olast_reg;
        if (cmd.load)
        begin
            acc_next   = (acc_reg << n_clamped) | msbbp_pkg::ACC_W'(value_masked);
            total_next = total_loaded;
        end
        if (cmd.pop)
        begin
            total_next  = total_reg - msbbp_pkg::TOTAL_W'(msbbp_pkg::BYTE_BITS);
            cnt_next    = cnt_reg + 1'b1;
            ovalid_next = 1'b1;
            obyte_next  = acc_shifted[msbbp_pkg::BYTE_BITS-1:0];
            oidx_next   = cnt_wide[msbbp_pkg::IDX_OUT_W-1:0];
            olast_next  = status.last_byte;
        end
        if (cmd.flush)
        begin
            if (total_reg != '0)
            begin
                ovalid_next = 1'b1;
                obyte_next  = acc_flush[msbbp_pkg::BYTE_BITS-1:0];
                oidx_next   = cnt_wide[msbbp_pkg::IDX_OUT_W-1:0];
                olast_next  = 1'b1;
            end
            acc_next   = '0;
            total_next = '0;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            total_reg  <= total_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        obyte_reg <= obyte_next;
        oidx_reg  <= oidx_next;
        olast_reg <= olast_next;
    end

    assign out_valid  = ovalid_reg;
    assign out_byte   = obyte_reg;
    assign byte_index = oidx_reg;
    assign out_last   = olast_reg;

endmodule

// File: src/msb_first_bit_packer.sv
// A request's bytes go from the bit accumulator through the output byte register;
//   a push completes k bytes (0..4); in_ready stays low until they are all emitted.
//   The single output register sets the rate: one byte per cycle while not stalled.
// Reset (rst_n low, async): fill count and byte index clear to zero, so no bits are pending,
//   the output channel goes empty and the block is ready for a request.
// Top level of the MSB-first bit packer; depends on msbbp_pkg, msbbp_ctrl, msbbp_datapath.
module msb_first_bit_packer
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input request channel
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] field_value, [37:32] num_bits, [39:38] zero
    input  logic [msbbp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] action (0 push, 1 flush and restart)
    input  logic                                s_axis_tuser,
    // output byte channel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] out_byte, [23:8] byte_index
    output logic [msbbp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // last byte caused by the request
    output logic                                m_axis_tlast
);

    msbbp_pkg::dp_cmd_t               cmd;
    msbbp_pkg::dp_status_t            status;
    logic [msbbp_pkg::BYTE_BITS-1:0]  out_byte;
    logic [msbbp_pkg::IDX_OUT_W-1:0]  byte_index;

    msbbp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    msbbp_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .field_value (s_axis_tdata[msbbp_pkg::FIELD_BITS-1:0]),
        .num_bits    (s_axis_tdata[msbbp_pkg::FIELD_BITS +: msbbp_pkg::NBITS_W]),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_byte    (out_byte),
        .byte_index  (byte_index),
        .out_last    (m_axis_tlast)
    );

    // byte in the low bits, index above it, zero fill to whole bytes
    assign m_axis_tdata = msbbp_pkg::OUT_DATA_W'({byte_index, out_byte});

endmodule
